### src/wavh_pkg.sv
// Shared types, constants and helpers for the WAV header checker.
package wavh_pkg;

  // Result status codes; first failing check wins, but an early end reports short
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_BAD_RIFF     = 3'd2,
    ST_BAD_WAVE     = 3'd3,
    ST_BAD_FMT_TAG  = 3'd4,
    ST_BAD_FMT_SIZE = 3'd5,
    ST_BAD_BITS     = 3'd6,
    ST_BAD_CHUNK    = 3'd7
  } status_t;

  // Input item: one header byte plus framing flags
  typedef struct packed {
    logic [7:0] header_byte;
    logic       first_byte;
    logic       end_of_data;
  } in_item_t;

  // Result item
  typedef struct packed {
    status_t            status;
    logic signed [15:0] num_channels;
    logic [31:0]        sample_rate;
    logic [5:0]         bits_per_sample;
    logic [22:0]        period_frames;
  } out_item_t;

  // Configuration port
  localparam int             CFG_ADDR_W     = 3;
  localparam int             CFG_DATA_W     = 32;
  localparam logic           CFG_IDX_PERIOD = 1'b0;
  localparam int             PERIOD_W       = 10;
  localparam logic [9:0]     PERIOD_RESET   = 10'd50;

  // Header layout
  localparam logic [5:0]     HDR_LEN        = 6'd44;
  localparam logic [31:0]    TAG_RIFF       = 32'h52494646;
  localparam logic [31:0]    TAG_WAVE       = 32'h57415645;
  localparam logic [31:0]    TAG_FMT        = 32'h666D7420;
  localparam logic [31:0]    TAG_FACT       = 32'h66616374;
  localparam logic [31:0]    TAG_DATA       = 32'h64617461;
  localparam logic [31:0]    FMT_SIZE_SHORT = 32'd16;
  localparam logic [31:0]    FMT_SIZE_LONG  = 32'd18;
  localparam logic [15:0]    BITS_8         = 16'd8;
  localparam logic [15:0]    BITS_16        = 16'd16;
  localparam logic [15:0]    BITS_32        = 16'd32;

  // x/1000 for any 32-bit x: (x * RECIP_1000) >> RECIP_SHIFT
  localparam int             FRAMES_W       = 23;
  localparam logic [28:0]    RECIP_1000     = 29'd274877907;
  localparam int             RECIP_SHIFT    = 38;

  // Byte idx of a tag in file order (first character is the top byte)
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = tag[31:24];
      2'd1:    b = tag[23:16];
      2'd2:    b = tag[15:8];
      default: b = tag[7:0];
    endcase
    return b;
  endfunction

endpackage

### src/wavh_parser.sv
// Byte-at-a-time header parser: tag checks, field capture, result trigger.
module wavh_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  wavh_pkg::in_item_t  item,
  output logic                res_valid,
  output wavh_pkg::out_item_t res_item
);
  import wavh_pkg::*;

  typedef struct packed {
    logic [5:0]  pos;
    status_t     err;
    logic [31:0] fmt;
    logic [15:0] chan;
    logic [31:0] rate;
    logic [15:0] width;
    logic        fact;
    logic        data;
    logic        sent;
  } parse_t;

  localparam parse_t PARSE_CLEAR = '{
    pos: '0, err: ST_OK, fmt: '0, chan: '0, rate: '0, width: '0,
    fact: 1'b1, data: 1'b1, sent: 1'b0
  };

  // Field offsets
  localparam logic [5:0] OFS_WAVE  = 6'd8;
  localparam logic [5:0] OFS_FMT   = 6'd12;
  localparam logic [5:0] OFS_FSIZE = 6'd16;
  localparam logic [5:0] OFS_CHAN  = 6'd22;
  localparam logic [5:0] OFS_RATE  = 6'd24;
  localparam logic [5:0] OFS_BITS  = 6'd34;
  localparam logic [5:0] OFS_TAG_S = 6'd36;
  localparam logic [5:0] OFS_TAG_L = 6'd38;

  parse_t      st_r, st_nxt, cur;
  logic        emit;
  status_t     emit_status;
  logic [5:0]  pos;
  logic [7:0]  b;
  logic [5:0]  tag_start;
  logic [5:0]  tag_off;

  // Next parse state for the item being accepted
  always_comb begin
    cur         = item.first_byte ? PARSE_CLEAR : st_r;
    st_nxt      = cur;
    emit        = 1'b0;
    emit_status = ST_SHORT;
    b           = item.header_byte;
    pos         = cur.pos;
    tag_start   = OFS_TAG_S;
    tag_off     = '0;
    if (!cur.sent) begin
      if (item.end_of_data) begin
        emit        = 1'b1;
        emit_status = ST_SHORT;
        st_nxt.sent = 1'b1;
      end else if (pos >= HDR_LEN) begin
        st_nxt.sent = 1'b1;
      end else begin
        // fixed tags and field capture
        if (pos < 6'd4) begin
          if (b != tag_byte(TAG_RIFF, pos[1:0]) && st_nxt.err == ST_OK)
            st_nxt.err = ST_BAD_RIFF;
        end else if (pos >= OFS_WAVE && pos < OFS_FMT) begin
          if (b != tag_byte(TAG_WAVE, pos[1:0]) && st_nxt.err == ST_OK)
            st_nxt.err = ST_BAD_WAVE;
        end else if (pos >= OFS_FMT && pos < OFS_FSIZE) begin
          if (b != tag_byte(TAG_FMT, pos[1:0]) && st_nxt.err == ST_OK)
            st_nxt.err = ST_BAD_FMT_TAG;
        end else if (pos >= OFS_FSIZE && pos < 6'd20) begin
          st_nxt.fmt = cur.fmt | (32'(b) << {pos[1:0], 3'b000});
          if (pos == 6'd19 && st_nxt.fmt != FMT_SIZE_SHORT && st_nxt.fmt != FMT_SIZE_LONG
              && st_nxt.err == ST_OK)
            st_nxt.err = ST_BAD_FMT_SIZE;
        end else if (pos == OFS_CHAN || pos == 6'd23) begin
          st_nxt.chan = cur.chan | (16'(b) << {pos[0], 3'b000});
        end else if (pos >= OFS_RATE && pos < 6'd28) begin
          st_nxt.rate = cur.rate | (32'(b) << {pos[1:0], 3'b000});
        end else if (pos == OFS_BITS || pos == 6'd35) begin
          st_nxt.width = cur.width | (16'(b) << {pos[0], 3'b000});
          if (pos == 6'd35 && st_nxt.width != BITS_8 && st_nxt.width != BITS_16
              && st_nxt.width != BITS_32 && st_nxt.err == ST_OK)
            st_nxt.err = ST_BAD_BITS;
        end

        // chunk tag after fmt, shifted by two when fmt carries the extra size word
        tag_start = (st_nxt.fmt == FMT_SIZE_LONG) ? OFS_TAG_L : OFS_TAG_S;
        tag_off   = pos - tag_start;
        if (pos >= tag_start && tag_off < 6'd4) begin
          if (b != tag_byte(TAG_FACT, tag_off[1:0])) st_nxt.fact = 1'b0;
          if (b != tag_byte(TAG_DATA, tag_off[1:0])) st_nxt.data = 1'b0;
          if (tag_off == 6'd3 && !st_nxt.fact && !st_nxt.data && st_nxt.err == ST_OK)
            st_nxt.err = ST_BAD_CHUNK;
        end

        // advance; last header byte fires the result
        st_nxt.pos = pos + 6'd1;
        if (st_nxt.pos == HDR_LEN) begin
          emit        = 1'b1;
          emit_status = st_nxt.err;
          st_nxt.sent = 1'b1;
        end
      end
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PARSE_CLEAR;
    end else if (acc) begin
      st_r <= st_nxt;
    end
  end

  // Result fields; frames are filled in downstream
  always_comb begin
    res_valid                = acc & emit;
    res_item.status          = emit_status;
    res_item.num_channels    = st_nxt.chan;
    res_item.sample_rate     = st_nxt.rate;
    res_item.bits_per_sample = st_nxt.width[5:0];
    res_item.period_frames   = '0;
  end

endmodule

### src/wavh_period.sv
// Result pipeline: rate*period product, divide by 1000, output register.
module wavh_period (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [wavh_pkg::PERIOD_W-1:0] period,
  input  logic                          res_valid,
  input  wavh_pkg::out_item_t           res_item,
  output logic                          res_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wavh_pkg::out_item_t           out_data
);
  import wavh_pkg::*;

  logic        v1_r, v2_r, v3_r;
  out_item_t   item1_r, item2_r, item3_r, item3_nxt;
  logic [31:0] prod2_r, prod2_nxt;
  logic [31+PERIOD_W:0] prod_full;
  logic [60:0] recip_full;
  logic        rdy1, rdy2, rdy3;

  // Per-stage flow control: a stage moves when the next has room
  assign rdy3      = !v3_r || out_ready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign res_ready = rdy1;

  // Stage 2: product, wraps to 32 bits
  assign prod_full = item1_r.sample_rate * period;
  assign prod2_nxt = prod_full[31:0];

  // Stage 3: divide by 1000 via reciprocal, zero unless status is ok
  assign recip_full = prod2_r * RECIP_1000;
  always_comb begin
    item3_nxt = item2_r;
    item3_nxt.period_frames = (item2_r.status == ST_OK) ?
                              recip_full[RECIP_SHIFT +: FRAMES_W] : '0;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= res_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (rdy1 && res_valid) item1_r <= res_item;
    if (rdy2 && v1_r) begin
      item2_r <= item1_r;
      prod2_r <= prod2_nxt;
    end
    if (rdy3 && v2_r) item3_r <= item3_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = item3_r;

endmodule

### src/wav_header_checker.sv
// Top level of the WAV header checker: register port, parser, result pipeline.
// The block takes one header byte per clock with no gaps of its own. Each byte
// updates the parse state in the cycle it is accepted; the result for a header
// (after byte 44, or at an early end) enters a three-register result path that
// multiplies rate by the period, divides by 1000 through a reciprocal multiply,
// and holds the item in the output register; out_valid rises once the item has
// passed through item1_r, item2_r and item3_r. in_ready drops only when all three
// result registers are full and out_ready is low. Register 0 at address 0 holds
// the period in ms (reset 50); write it only while the block is idle.
module wav_header_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  wavh_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output wavh_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wavh_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wavh_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wavh_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import wavh_pkg::*;

  logic [PERIOD_W-1:0] period_r;
  logic                cfg_wr;
  logic                acc;
  logic                res_valid;
  out_item_t           res_item;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == CFG_IDX_PERIOD);
  assign prdata = (paddr[CFG_ADDR_W-1] == CFG_IDX_PERIOD) ? CFG_DATA_W'(period_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_wr) begin
      period_r <= pwdata[PERIOD_W-1:0];
    end
  end

  assign acc = in_valid && in_ready;

  wavh_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .item      (in_data),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  wavh_period u_period (
    .clk       (clk),
    .rst_n     (rst_n),
    .period    (period_r),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_ready (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Frames only on a good header
  a_frames_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.period_frames == '0)
    else $error("period_frames nonzero on failed header");

  // Restart together with end always reports a short header
  a_restart_end: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.first_byte && in_data.end_of_data |-> res_valid && res_item.status == ST_SHORT)
    else $error("restart with end did not give short status");

  // Results come only from accepted items
  a_res_acc: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> acc)
    else $error("result without accepted item");

  // Period write lands
  a_cfg_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> period_r == $past(pwdata[PERIOD_W-1:0]))
    else $error("period register write lost");

endmodule
